// ===== hw/rtl/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int LEVELS      = 4;
  localparam int ID_BITS     = 8;
  localparam int TIME_BITS   = 16;
  localparam int QUANT_W     = 8;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W     = 2;
  localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ENTRY_W   = ID_BITS + TIME_BITS;
  localparam int NUM_QREGS = LEVELS - 1;
  localparam int CFG_IDX_W = 2;

  typedef logic [QUANT_W-1:0] quant_t;
  typedef quant_t [NUM_QREGS-1:0] quant_arr_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_L0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_L1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_L2 = 2'd2;

  // quantum reset values, one per limited level
  localparam quant_t QUANTUM_RESET_L0 = 8'd1;
  localparam quant_t QUANTUM_RESET_L1 = 8'd2;
  localparam quant_t QUANTUM_RESET_L2 = 8'd6;

  // input command codes
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_e;

  // what the load step does with the running task
  typedef enum logic [1:0] {
    LD_KEEP,
    LD_ARRIVE,
    LD_POP,
    LD_NONE
  } ld_kind_e;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } ctrl_t;

  // wrap-around pointer increment
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ===== hw/rtl/multilevel_feedback_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// Four-level feedback queue scheduler with programmable level quanta.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (cmd_i, task_id_i, burst_time_i) is taken at a
//   rising edge with start_i high and busy_o low. cmd_i selects a scheduler
//   tick or a task arrival.
//   Result channel: done_o is high for exactly one cycle; running_* and
//   remaining_time_o and queue_full_error_o are valid in that cycle only.
//   The receiver cannot stall, so no result is ever held back.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i selecting the
//   level 0, 1 or 2 quantum; index 3 is ignored. Write only while idle.
// Timing:
//   A word runs an exec step for the FIFO pointer update with the shared
//   queue memory read and write, then a load step for the running task from the
//   registered read data. done_o rises the cycle after that load, and a new
//   word can be accepted in the load cycle, before the last word's result is out.
// Reset:
//   All queues empty, nothing running, quanta back to 1, 2 and 6. Queue
//   memory is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core import mlfq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 cmd_i,
  input  logic [ID_BITS-1:0]   task_id_i,
  input  logic [TIME_BITS-1:0] burst_time_i,
  output logic                 done_o,
  output logic                 running_valid_o,
  output logic [ID_BITS-1:0]   running_id_o,
  output logic [LVL_W-1:0]     running_level_o,
  output logic [TIME_BITS-1:0] remaining_time_o,
  output logic                 queue_full_error_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [QUANT_W-1:0]   cfg_data_i
);

  ctrl_t      ctrl;
  quant_arr_t quantum;

  // quantum registers
  mlfq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .quantum_o   (quantum)
  );

  // sequencer
  mlfq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .ctrl_o  (ctrl)
  );

  // queues and running task
  mlfq_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .quantum_i          (quantum),
    .cmd_i              (cmd_i),
    .task_id_i          (task_id_i),
    .burst_time_i       (burst_time_i),
    .running_valid_o    (running_valid_o),
    .running_id_o       (running_id_o),
    .running_level_o    (running_level_o),
    .remaining_time_o   (remaining_time_o),
    .queue_full_error_o (queue_full_error_o)
  );

endmodule

// ===== hw/rtl/mlfq_cfg.sv =====
// ----------------------------------------------------------------------------
// mlfq_cfg
// Quantum register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module mlfq_cfg import mlfq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [QUANT_W-1:0]   cfg_data_i,
  output quant_arr_t           quantum_o
);

  quant_arr_t quantum_q;

  // always able to take a word
  assign cfg_ready_o = 1'b1;

  // register writes; unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q[0] <= QUANTUM_RESET_L0;
      quantum_q[1] <= QUANTUM_RESET_L1;
      quantum_q[2] <= QUANTUM_RESET_L2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_QUANTUM_L0: quantum_q[0] <= cfg_data_i;
        CFG_QUANTUM_L1: quantum_q[1] <= cfg_data_i;
        CFG_QUANTUM_L2: quantum_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign quantum_o = quantum_q;

endmodule

// ===== hw/rtl/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: accept a command, run the queue step, then load the run state.
// ----------------------------------------------------------------------------
module mlfq_ctrl import mlfq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output logic  done_o,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   done_q;
  logic   accept;

  // state register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ctrl_o.load;
    end
  end

  assign busy_o = (state_q == ST_EXEC);
  assign accept = start_i && !busy_o;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    ctrl_o.latch = accept;
    ctrl_o.exec  = 1'b0;
    ctrl_o.load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl_o.load = 1'b1;
        state_d     = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== hw/rtl/mlfq_datapath.sv =====
// ----------------------------------------------------------------------------
// mlfq_datapath
// Level FIFOs (shared memory plus pointers), running task registers and the
// reschedule decision.
// ----------------------------------------------------------------------------
module mlfq_datapath import mlfq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  input  quant_arr_t           quantum_i,
  input  logic                 cmd_i,
  input  logic [ID_BITS-1:0]   task_id_i,
  input  logic [TIME_BITS-1:0] burst_time_i,
  output logic                 running_valid_o,
  output logic [ID_BITS-1:0]   running_id_o,
  output logic [LVL_W-1:0]     running_level_o,
  output logic [TIME_BITS-1:0] remaining_time_o,
  output logic                 queue_full_error_o
);

  // latched command word
  logic                 cmd_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] burst_q;

  // FIFO bookkeeping
  logic [LEVELS-1:0][PTR_W-1:0] head_q, tail_q;
  logic [LEVELS-1:0][CNT_W-1:0] cnt_q, cnt_a, cnt_d;
  logic [ENTRY_W-1:0]           fifo_mem_q [MEM_DEPTH];
  logic [ENTRY_W-1:0]           rd_data_q;

  // running task
  logic                 run_valid_q, run_valid_d;
  logic [ID_BITS-1:0]   run_id_q, run_id_d;
  logic [TIME_BITS-1:0] run_time_q, run_time_d;
  logic [LVL_W-1:0]     run_level_q, run_level_d;
  quant_t               qleft_q, qleft_d;

  // decision handed from exec to load
  ld_kind_e         kind_q, kind_d;
  logic [LVL_W-1:0] sel_q;
  logic             bypass_q, drop_q, tick_q;

  // exec step signals
  logic               arrive, expired, finished, resched;
  logic               push_en, push_ok, pop_en, found, bypass, drop;
  logic [LVL_W-1:0]   push_lvl, sel;
  logic [ENTRY_W-1:0] push_data;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;

  // load step signals
  logic [ID_BITS-1:0]   pop_id;
  logic [TIME_BITS-1:0] pop_time;

  // input latch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q   <= cmd_i;
      id_q    <= task_id_i;
      burst_q <= burst_time_i;
    end
  end

  // reschedule decision and push of the arrival or demoted task
  always_comb begin
    arrive   = (cmd_q == CMD_ARRIVE);
    expired  = run_valid_q && (run_level_q != LVL_W'(LEVELS - 1)) && (qleft_q == '0);
    finished = run_valid_q && (run_time_q == '0);
    resched  = !arrive && (!run_valid_q || expired || finished);
    push_en  = 1'b0;
    push_lvl = '0;
    if (arrive) begin
      push_en = run_valid_q;
    end else if (resched && run_valid_q && !finished) begin
      push_en  = 1'b1;
      push_lvl = (run_level_q == LVL_W'(LEVELS - 1)) ? run_level_q
                                                      : run_level_q + LVL_W'(1);
    end
    push_ok   = push_en && (cnt_q[push_lvl] != CNT_W'(QUEUE_DEPTH));
    drop      = push_en && !push_ok;
    push_data = arrive ? {id_q, burst_q} : {run_id_q, run_time_q};
  end

  // counts after the push, then first non-empty level
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      cnt_a[l] = cnt_q[l] + CNT_W'(push_ok && (push_lvl == LVL_W'(l)));
    end
    found = 1'b0;
    sel   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_a[l] != '0) begin
        found = 1'b1;
        sel   = LVL_W'(l);
      end
    end
    pop_en = resched && found;
    // popping the task just pushed into an empty FIFO: take it from the regs
    bypass = push_ok && (sel == push_lvl) && (cnt_q[sel] == '0);
    for (int l = 0; l < LEVELS; l++) begin
      cnt_d[l] = cnt_a[l] - CNT_W'(pop_en && (sel == LVL_W'(l)));
    end
    priority if (arrive) kind_d = run_valid_q ? LD_KEEP : LD_ARRIVE;
    else if (!resched)   kind_d = LD_KEEP;
    else if (found)      kind_d = LD_POP;
    else                 kind_d = LD_NONE;
  end

  assign wr_addr = ADDR_W'(push_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[push_lvl]);
  assign rd_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[sel]);

  // FIFO storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (push_ok) fifo_mem_q[wr_addr] <= push_data;
      rd_data_q <= fifo_mem_q[rd_addr];
    end
  end

  // pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (ctrl_i.exec) begin
      for (int l = 0; l < LEVELS; l++) begin
        if (push_ok && (push_lvl == LVL_W'(l))) tail_q[l] <= next_ptr(tail_q[l]);
        if (pop_en && (sel == LVL_W'(l)))       head_q[l] <= next_ptr(head_q[l]);
        cnt_q[l] <= cnt_d[l];
      end
    end
  end

  // decision registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= LD_KEEP;
      sel_q    <= '0;
      bypass_q <= 1'b0;
      drop_q   <= 1'b0;
      tick_q   <= 1'b0;
    end else if (ctrl_i.exec) begin
      kind_q   <= kind_d;
      sel_q    <= sel;
      bypass_q <= bypass;
      drop_q   <= drop;
      tick_q   <= !arrive;
    end
  end

  // load step: new running task, then tick countdown
  assign pop_id   = bypass_q ? run_id_q : rd_data_q[ENTRY_W-1:TIME_BITS];
  assign pop_time = bypass_q ? run_time_q : rd_data_q[TIME_BITS-1:0];

  always_comb begin
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    run_time_d  = run_time_q;
    run_level_d = run_level_q;
    qleft_d     = qleft_q;
    unique case (kind_q)
      LD_KEEP: ;
      LD_ARRIVE: begin
        run_valid_d = 1'b1;
        run_id_d    = id_q;
        run_time_d  = burst_q;
        run_level_d = '0;
        qleft_d     = quantum_i[0];
      end
      LD_POP: begin
        run_valid_d = 1'b1;
        run_id_d    = pop_id;
        run_time_d  = pop_time;
        run_level_d = sel_q;
        qleft_d     = (sel_q == LVL_W'(LEVELS - 1)) ? '0 : quantum_i[sel_q];
      end
      LD_NONE: run_valid_d = 1'b0;
      default: ;
    endcase
    if (tick_q) begin
      if (run_valid_d && (run_time_d != '0)) run_time_d = run_time_d - TIME_BITS'(1);
      if (qleft_d != '0)                     qleft_d    = qleft_d - QUANT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_time_q  <= '0;
      run_level_q <= '0;
      qleft_q     <= QUANTUM_RESET_L0;
    end else if (ctrl_i.load) begin
      run_valid_q <= run_valid_d;
      run_id_q    <= run_id_d;
      run_time_q  <= run_time_d;
      run_level_q <= run_level_d;
      qleft_q     <= qleft_d;
    end
  end

  // result word, zeroed when idle
  assign running_valid_o    = run_valid_q;
  assign running_id_o       = run_valid_q ? run_id_q : '0;
  assign running_level_o    = run_valid_q ? run_level_q : '0;
  assign remaining_time_o   = run_valid_q ? run_time_q : '0;
  assign queue_full_error_o = drop_q;

endmodule
